/* rtl/core/dds_tuning_word_serial_loader_defines.svh */
// Assertion macros shared by the loader RTL.
// Both sample on clk_i; the first is masked while rst_ni is low.
`ifndef DDS_TUNING_WORD_SERIAL_LOADER_DEFINES_SVH
`define DDS_TUNING_WORD_SERIAL_LOADER_DEFINES_SVH

// Clocked property, ignored during reset.
`define DTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked property, checked during reset as well.
`define DTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/core/dtw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dtw_pkg;

  localparam int unsigned FreqW     = 28;
  localparam int unsigned PhaseW    = 5;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned CtrlBits  = 8;
  localparam int unsigned SerBits   = WordBits + CtrlBits;
  localparam int unsigned CntW      = $clog2(SerBits + 1);
  localparam int unsigned NumBits   = FreqW + WordBits;
  localparam int unsigned DivCycles = NumBits / 2;
  localparam int unsigned StepW     = $clog2(DivCycles);

  localparam logic [FreqW-1:0] RefClkReset = FreqW'(125000000);
  localparam logic [CntW-1:0]  LatchIdx    = CntW'(SerBits);
  localparam logic [StepW-1:0] LastStep    = StepW'(DivCycles - 1);

  // One queued frame: tuning word, then control byte.
  typedef struct packed {
    logic [CtrlBits-1:0] ctrl;
    logic [WordBits-1:0] word;
  } frame_t;

  // Control byte: phase in bits 7..3, power-down in bit 2, bits 1..0 zero.
  function automatic logic [CtrlBits-1:0] make_ctrl(logic [PhaseW-1:0] phase,
                                                    logic              pd);
    make_ctrl = {phase, pd, 2'b00};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dtw_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dtw_req_if
  import dtw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FreqW-1:0]  freq_hz;
  logic [PhaseW-1:0] phase;
  logic              power_down;

  modport source (output valid, freq_hz, phase, power_down, input ready);
  modport sink   (input valid, freq_hz, phase, power_down, output ready);
endinterface

`default_nettype wire

/* rtl/core/dtw_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface dtw_res_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic latch_pulse;
  logic last;

  modport source (output valid, data_bit, latch_pulse, last, input ready);
  modport sink   (input valid, data_bit, latch_pulse, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/dtw_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dds_tuning_word_serial_loader_defines.svh"

module dtw_front
  import dtw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [FreqW-1:0] cfg_wdata_i,
  dtw_req_if.sink               req,
  output logic                  push_o,
  output frame_t                push_data_o,
  input  wire logic             full_i
);

  logic [FreqW-1:0]    ref_clk_q, ref_clk_d;
  logic                busy_q, busy_d;
  logic                pend_q, pend_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [NumBits-1:0]  num_q, num_d;
  logic [FreqW-1:0]    rem_q, rem_d;
  logic [FreqW-1:0]    div_q, div_d;
  logic [WordBits-1:0] quo_q, quo_d;
  logic [CtrlBits-1:0] ctrl_q, ctrl_d;
  logic                accept;
  logic [FreqW:0]      s1, s2;

  // One restoring step: returns {quotient bit, new remainder}.
  function automatic logic [FreqW:0] div_step(logic [FreqW-1:0] r, logic b,
                                              logic [FreqW-1:0] d);
    logic [FreqW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, FreqW'(t - {1'b0, d})};
    end else begin
      div_step = {1'b0, t[FreqW-1:0]};
    end
  endfunction

  assign req.ready   = !busy_q && (!pend_q || !full_i);
  assign accept      = req.valid && req.ready;
  assign push_o      = pend_q && !full_i;
  assign push_data_o = '{ctrl: ctrl_q, word: quo_q};

  // Two quotient bits per cycle.
  assign s1 = div_step(rem_q, num_q[NumBits-1], div_q);
  assign s2 = div_step(s1[FreqW-1:0], num_q[NumBits-2], div_q);

  always_comb begin
    ref_clk_d = cfg_we_i ? cfg_wdata_i : ref_clk_q;
    busy_d    = busy_q;
    pend_d    = pend_q;
    step_d    = step_q;
    num_d     = num_q;
    rem_d     = rem_q;
    div_d     = div_q;
    quo_d     = quo_q;
    ctrl_d    = ctrl_q;
    if (push_o) begin
      pend_d = 1'b0;
    end
    if (busy_q) begin
      rem_d  = s2[FreqW-1:0];
      num_d  = {num_q[NumBits-3:0], 2'b00};
      quo_d  = {quo_q[WordBits-3:0], s1[FreqW], s2[FreqW]};
      step_d = step_q + StepW'(1);
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        pend_d = 1'b1;
      end
    end else if (accept && (ref_clk_q != '0)) begin
      // numerator = freq * 2^32 + ref / 2; the half never carries past bit 31
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      div_d  = ref_clk_q;
      num_d  = {req.freq_hz, WordBits'(ref_clk_q[FreqW-1:1])};
      ctrl_d = make_ctrl(req.phase, req.power_down);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_clk_q <= RefClkReset;
      busy_q    <= 1'b0;
      pend_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      ref_clk_q <= ref_clk_d;
      busy_q    <= busy_d;
      pend_q    <= pend_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    quo_q  <= quo_d;
    ctrl_q <= ctrl_d;
  end

  `DTW_ASSERT(a_busy_pend_excl, !(busy_q && pend_q), "divider busy with result pending")
  `DTW_ASSERT(a_push_not_full, push_o |-> !full_i, "push into full queue")

endmodule

`default_nettype wire

/* rtl/core/dtw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dds_tuning_word_serial_loader_defines.svh"

module dtw_fifo
  import dtw_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t push_data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        pop_valid_o,
  output frame_t      pop_data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  frame_t          mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CW'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
    nxt = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `DTW_ASSERT(a_cnt_range, cnt_q <= CW'(Depth), "queue count overflow")

endmodule

`default_nettype wire

/* rtl/core/dtw_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "dds_tuning_word_serial_loader_defines.svh"

module dtw_back
  import dtw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   pop_valid_i,
  input  wire frame_t pop_data_i,
  output logic        pop_o,
  dtw_res_if.source   res
);

  logic               busy_q, busy_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SerBits-1:0] sr_q, sr_d;
  logic               ov_q, ov_d;
  logic               od_q, od_d;
  logic               ol_q, ol_d;
  logic               adv;

  assign adv             = !ov_q || res.ready;
  assign res.valid       = ov_q;
  assign res.data_bit    = od_q;
  assign res.latch_pulse = ol_q;
  assign res.last        = ol_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sr_d   = sr_q;
    ov_d   = ov_q && !res.ready;
    od_d   = od_q;
    ol_d   = ol_q;
    pop_o  = 1'b0;
    if (busy_q) begin
      if (adv) begin
        ov_d = 1'b1;
        if (cnt_q == LatchIdx) begin
          od_d = 1'b0;
          ol_d = 1'b1;
          // chain straight into the next frame, no idle slot
          pop_o  = pop_valid_i;
          busy_d = pop_valid_i;
          cnt_d  = '0;
          sr_d   = pop_data_i;
        end else begin
          od_d  = sr_q[0];
          ol_d  = 1'b0;
          sr_d  = {1'b0, sr_q[SerBits-1:1]};
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        ov_d = ov_q;
      end
    end else if (pop_valid_i) begin
      pop_o  = 1'b1;
      busy_d = 1'b1;
      cnt_d  = '0;
      sr_d   = pop_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    od_q <= od_d;
    ol_q <= ol_d;
  end

  `DTW_ASSERT(a_latch_zero, (ov_q && ol_q) |-> !od_q, "latch transaction with data bit set")
  `DTW_ASSERT(a_cnt_range, busy_q |-> (cnt_q <= LatchIdx), "bit counter past latch slot")

endmodule

`default_nettype wire

/* rtl/core/dds_tuning_word_serial_loader.sv */
// Path: an accepted request reaches the first serial bit through the divider, result
//   register, queue and output register; output stalls delay it further.
// Throughput: 41 output transactions per request, one per cycle while the sink is ready;
//   the bit serializer sets the sustained request rate, the divider overlaps with it.
// Reset: rst_ni async active low; reference clock returns to 125000000 Hz, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module dds_tuning_word_serial_loader
  import dtw_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // reference clock register, to be written only while idle; the block does not enforce this
  input  wire logic             cfg_we_i,
  input  wire logic [FreqW-1:0] cfg_wdata_i,
  dtw_req_if.sink               req_i,
  dtw_res_if.source             res_o
);

  // Front: takes requests, drops them when the reference clock is zero,
  // and computes round(freq * 2^32 / ref) two quotient bits a cycle.
  // A request with a zero reference clock is taken and produces nothing.
  logic   push, full, pop, pop_valid;
  frame_t push_data, pop_data;

  dtw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Short frame queue so the divider keeps working while bits shift out.
  dtw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  // Back: 32 word bits LSB first, 8 control bits, then the latch transaction.
  // The output register holds each transaction until the sink's ready takes it.
  dtw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .res         (res_o)
  );

endmodule

`default_nettype wire
